@@ hdl/natural_log_atanh_series_defines.svh @@
// Assertion macros for the natural logarithm block checker.
// No dependencies; taken in by the checker file with an include.
`ifndef NATURAL_LOG_ATANH_SERIES_DEFINES_SVH
`define NATURAL_LOG_ATANH_SERIES_DEFINES_SVH

// Same-cycle implication, checked on the rising clock, off while in reset.
`define NLAS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on the rising clock, off while in reset.
`define NLAS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/nlas_pkg.sv @@
// Shared constants and types for the natural logarithm block.
// No dependencies; used by the top level and by its checker.
`timescale 1ns / 1ps

package nlas_pkg;

	localparam int X_W     = 48;  // argument, unsigned, 16 fraction bits
	localparam int LN_W    = 48;  // result, signed, 32 fraction bits
	localparam int TERMS_W = 11;  // term count register
	localparam int FRAC_Y  = 60;  // fraction bits of y and its powers
	localparam int SUM_W   = 64;  // series sum, 60 fraction bits
	localparam int HALF_W  = FRAC_Y / 2;

	localparam logic [TERMS_W-1:0] MAX_TERMS   = 11'd1024;
	localparam logic [TERMS_W-1:0] TERMS_RESET = 11'd256;
	localparam logic [X_W-1:0]     ONE_Q16     = 48'h0000_0001_0000;
	localparam logic [FRAC_Y-1:0]  Y_MAX       = {FRAC_Y{1'b1}};
	localparam logic [LN_W-1:0]    LN_POS_LIM  = 48'h7FFF_FFFF_FFFF;
	localparam logic [LN_W-1:0]    LN_NEG_LIM  = 48'h8000_0000_0000;

	typedef logic [X_W-1:0]    x_t;
	typedef logic [LN_W-1:0]   ln_t;
	typedef logic [TERMS_W-1:0] terms_t;
	typedef logic [FRAC_Y-1:0] frac_t;

endpackage

@@ hdl/natural_log_atanh_series.sv @@
// Natural logarithm of an unsigned Q32.16 argument by the atanh series.
// Depends on nlas_pkg for widths, limits and types.
`timescale 1ns / 1ps

// Channel   | Direction | Signals                    | Handshake
// ----------+-----------+----------------------------+------------------------------
// argument  | in        | x_value                    | taken when start & !busy
// result    | out       | ln_value, invalid          | shown one cycle with done
// config    | in        | cfg_data (num_terms)       | written when cfg_valid & cfg_ready
//
// One item runs a restoring divider for y = (x-1)/(x+1), rounds y and forms y squared on a
// 30x30 multiplier used four times, then per term runs a radix-16 divider, adds the term
// and forms the next power, up to the term count and stopping early once the power
// vanishes; a zero argument answers on the next cycle.
// The block is busy for the whole of a nonzero item and takes no new item meanwhile.
// Reset clears the sequencer and sets the term count to 256.
// The receiver cannot stall: done marks the result for exactly one cycle.

module natural_log_atanh_series (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  nlas_pkg::x_t           x_value,
	output logic                   done,
	output logic signed [nlas_pkg::LN_W-1:0] ln_value,
	output logic                   invalid,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  nlas_pkg::terms_t       cfg_data
);
	import nlas_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_YDIV = 3'd1;
	localparam logic [2:0] S_YRND = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_MRND = 3'd4;
	localparam logic [2:0] S_CHK  = 3'd5;
	localparam logic [2:0] S_TDIV = 3'd6;
	localparam logic [2:0] S_TADD = 3'd7;

	localparam logic [5:0] YDIV_LAST = 6'd59;
	localparam logic [5:0] TDIV_LAST = 6'd14;
	localparam logic [5:0] MUL_LAST  = 6'd4;

	logic [2:0]        state_q;
	logic [5:0]        cnt_q;
	terms_t            num_terms_q;
	terms_t            terms_q;
	terms_t            n_q;
	logic              neg_q;
	logic              first_q;
	logic              fin_q;

	logic [X_W:0]      den_q;
	logic [X_W:0]      yrem_q;
	frac_t             yq_q;

	frac_t             pw_q;
	frac_t             y2_q;
	logic [SUM_W-1:0]  sum_q;

	frac_t             dd_q;
	logic [TERMS_W-1:0] trem_q;
	frac_t             tq_q;

	frac_t             mul_a_q;
	frac_t             mul_b_q;
	logic [2*HALF_W-1:0] pp_q;
	logic [1:0]        psh_q;
	logic [2*FRAC_Y-1:0] acc_q;

	logic              done_q;
	ln_t               ln_q;
	logic              inv_q;

	// Configuration register; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_terms_q <= TERMS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			num_terms_q <= cfg_data;
		end
	end

	// One restoring step of the y divider, also used for its rounding.
	logic [X_W+1:0] yr2;
	logic           yge;
	logic [X_W:0]   yrem_nxt;
	logic [FRAC_Y:0] yq_rnd;

	always_comb begin
		yr2      = {yrem_q, 1'b0};
		yge      = (yr2 >= {1'b0, den_q});
		yrem_nxt = yge ? (X_W+1)'(yr2 - {1'b0, den_q}) : yr2[X_W:0];
		yq_rnd   = {1'b0, yq_q} + (FRAC_Y+1)'(yge);
	end

	// Four radix-2 steps of the term divider: 2n+1 is at most eleven bits.
	logic [TERMS_W-1:0] tdiv_d;
	logic [TERMS_W-1:0] trem_nxt;
	logic [3:0]         tq_bits;
	logic [TERMS_W:0]   tr2;
	logic [TERMS_W:0]   trem_dbl;
	logic               t_up;
	logic [FRAC_Y:0]    t_val;
	logic [SUM_W:0]     sum_ext;

	assign tdiv_d = {n_q[TERMS_W-2:0], 1'b1};

	always_comb begin
		trem_nxt = trem_q;
		tq_bits  = '0;
		tr2      = '0;
		for (int i = 0; i < 4; i++) begin
			tr2 = {trem_nxt, dd_q[FRAC_Y-1-i]};
			if (tr2 >= {1'b0, tdiv_d}) begin
				tr2        = tr2 - {1'b0, tdiv_d};
				tq_bits[3-i] = 1'b1;
			end
			trem_nxt = tr2[TERMS_W-1:0];
		end
		trem_dbl = {trem_q, 1'b0};
		t_up     = (trem_dbl >= {1'b0, tdiv_d});
		t_val    = {1'b0, tq_q} + (FRAC_Y+1)'(t_up);
		sum_ext  = {1'b0, sum_q} + (SUM_W+1)'(t_val);
	end

	// Partial product of the shared 30x30 multiplier.
	logic [HALF_W-1:0]   mop_a;
	logic [HALF_W-1:0]   mop_b;
	logic [2*FRAC_Y-1:0] pp_aligned;
	logic [FRAC_Y:0]     m_rnd;

	always_comb begin
		mop_a = cnt_q[1] ? mul_a_q[FRAC_Y-1:HALF_W] : mul_a_q[HALF_W-1:0];
		mop_b = cnt_q[0] ? mul_b_q[FRAC_Y-1:HALF_W] : mul_b_q[HALF_W-1:0];
		case (psh_q)
			2'd0:    pp_aligned = {(2*FRAC_Y-2*HALF_W)'(0), pp_q};
			2'd1:    pp_aligned = {(FRAC_Y-2*HALF_W+HALF_W)'(0), pp_q, (HALF_W)'(0)};
			default: pp_aligned = {pp_q, (FRAC_Y)'(0)};
		endcase
		m_rnd = {1'b0, acc_q[2*FRAC_Y-1:FRAC_Y]} + (FRAC_Y+1)'(acc_q[FRAC_Y-1]);
	end

	// Final scaling: twice the sum with 32 fraction bits, rounded, signed.
	logic [38:0] res_mag;
	ln_t         res_ext;
	ln_t         ln_fin;

	always_comb begin
		res_mag = {2'b00, sum_q[SUM_W-1:27]} + 39'(sum_q[26]);
		res_ext = LN_W'(res_mag);
		if (neg_q) begin
			ln_fin = (res_ext > LN_NEG_LIM) ? LN_NEG_LIM : LN_W'(0) - res_ext;
		end else begin
			ln_fin = (res_ext > LN_POS_LIM) ? LN_POS_LIM : res_ext;
		end
	end

	// Sequencer: control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			fin_q   <= 1'b0;
			first_q <= 1'b0;
			n_q     <= '0;
		end else begin
			done_q <= 1'b0;
			fin_q  <= 1'b0;
			if (fin_q) begin
				done_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (start && !busy) begin
						if (x_value == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_YDIV;
							cnt_q   <= '0;
						end
					end
				end
				S_YDIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == YDIV_LAST) begin
						state_q <= S_YRND;
					end
				end
				S_YRND: begin
					state_q <= S_MUL;
					cnt_q   <= '0;
					first_q <= 1'b1;
				end
				S_MUL: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == MUL_LAST) begin
						state_q <= S_MRND;
					end
				end
				S_MRND: begin
					state_q <= S_CHK;
					first_q <= 1'b0;
					n_q     <= first_q ? '0 : n_q + TERMS_W'(1);
				end
				S_CHK: begin
					cnt_q <= '0;
					if ((n_q >= terms_q) || (pw_q == '0)) begin
						state_q <= S_IDLE;
						fin_q   <= 1'b1;
					end else begin
						state_q <= S_TDIV;
					end
				end
				S_TDIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == TDIV_LAST) begin
						state_q <= S_TADD;
					end
				end
				S_TADD: begin
					state_q <= S_MUL;
					cnt_q   <= '0;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				neg_q   <= (x_value < ONE_Q16);
				yrem_q  <= (x_value < ONE_Q16) ? {1'b0, ONE_Q16 - x_value}
				                               : {1'b0, x_value - ONE_Q16};
				den_q   <= {1'b0, x_value} + {1'b0, ONE_Q16};
				terms_q <= (num_terms_q > MAX_TERMS) ? MAX_TERMS : num_terms_q;
				sum_q   <= '0;
			end
			S_YDIV: begin
				yrem_q <= yrem_nxt;
				yq_q   <= {yq_q[FRAC_Y-2:0], yge};
			end
			S_YRND: begin
				pw_q    <= yq_rnd[FRAC_Y] ? Y_MAX : yq_rnd[FRAC_Y-1:0];
				mul_a_q <= yq_rnd[FRAC_Y] ? Y_MAX : yq_rnd[FRAC_Y-1:0];
				mul_b_q <= yq_rnd[FRAC_Y] ? Y_MAX : yq_rnd[FRAC_Y-1:0];
				acc_q   <= '0;
			end
			S_MUL: begin
				if (cnt_q != MUL_LAST) begin
					pp_q  <= (2*HALF_W)'(mop_a * mop_b);
					psh_q <= 2'(cnt_q[1:0] == 2'd0 ? 2'd0 :
					            (cnt_q[1:0] == 2'd3 ? 2'd2 : 2'd1));
				end
				if (cnt_q != '0) begin
					acc_q <= acc_q + pp_aligned;
				end
			end
			S_MRND: begin
				if (first_q) begin
					y2_q <= m_rnd[FRAC_Y] ? Y_MAX : m_rnd[FRAC_Y-1:0];
				end else begin
					pw_q <= m_rnd[FRAC_Y] ? Y_MAX : m_rnd[FRAC_Y-1:0];
				end
			end
			S_CHK: begin
				dd_q   <= pw_q;
				trem_q <= '0;
				tq_q   <= '0;
				ln_q   <= ln_fin;
			end
			S_TDIV: begin
				dd_q   <= {dd_q[FRAC_Y-5:0], 4'b0000};
				trem_q <= trem_nxt;
				tq_q   <= {tq_q[FRAC_Y-5:0], tq_bits};
			end
			S_TADD: begin
				sum_q   <= sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
				mul_a_q <= pw_q;
				mul_b_q <= y2_q;
				acc_q   <= '0;
			end
			default: begin
			end
		endcase
	end

	// Result registers; a zero argument reports invalid at once.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			inv_q <= (x_value == '0);
		end
	end

	assign busy     = (state_q != S_IDLE) || fin_q;
	assign done     = done_q;
	assign invalid  = inv_q;
	assign ln_value = inv_q ? LN_NEG_LIM : ln_q;

endmodule

@@ hdl/nlas_chk.sv @@
// Port-level checker for the natural logarithm block, bound to the top level.
// Depends on nlas_pkg and on the assertion macros in the defines header.
`timescale 1ns / 1ps
`include "natural_log_atanh_series_defines.svh"

module nlas_chk (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   done,
	input logic                   invalid,
	input logic [nlas_pkg::LN_W-1:0] ln_value
);
	import nlas_pkg::*;

	// An accepted item either starts work or answers on the next cycle.
	`NLAS_ASSERT_NXT(a_accept_acts, start && !busy, busy || done, "accepted item was dropped")

	// A result is only shown once the block has finished its item.
	`NLAS_ASSERT_IMP(a_done_idle, done, !busy, "result shown while still busy")

	// A zero argument gives the most negative result.
	`NLAS_ASSERT_IMP(a_invalid_val, done && invalid, ln_value == LN_NEG_LIM, "invalid result value")

	// Work never begins without an accepted item.
	`NLAS_ASSERT_IMP(a_busy_cause, $rose(busy), $past(start), "busy rose without an item")

endmodule

bind natural_log_atanh_series nlas_chk u_nlas_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.invalid  (invalid),
	.ln_value (ln_value)
);

@@ tb/sv/nlas_result_checker.sv @@
// Result checker for the natural logarithm block: predicts ln(x) for every accepted item.
// Depends on nlas_pkg for widths, limits and types. It reports a failure count and a count
// of results still awaited.
`timescale 1ns / 1ps

module nlas_result_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             busy,
	input  nlas_pkg::x_t                     x_value,
	input  logic                             done,
	input  logic signed [nlas_pkg::LN_W-1:0] ln_value,
	input  logic                             invalid,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  nlas_pkg::terms_t                 cfg_data,
	output int                               ln_mismatches,
	output int                               ln_outstanding
);

	import nlas_pkg::*;

	localparam int SHOWN_MAX = 10;

	typedef struct packed {
		x_t   arg;
		ln_t  ln;
		logic inv;
	} ln_expect_t;

	ln_expect_t ln_expected_q[$];
	ln_expect_t want;
	terms_t     terms_shadow;
	int         fail_tally = 0;

	// Product of two magnitudes with 60 fraction bits, rounded half up and limited.
	function automatic frac_t frac_product(frac_t a, frac_t b);
		logic [2*FRAC_Y-1:0] prod;
		logic [FRAC_Y:0]     r;
		prod = a;
		prod = prod * b;
		r = prod[2*FRAC_Y-1:FRAC_Y] + prod[FRAC_Y-1];
		return (r > Y_MAX) ? Y_MAX : r[FRAC_Y-1:0];
	endfunction

	// Expected result of one argument under the given term count.
	function automatic ln_expect_t predict_ln(x_t arg, terms_t count);
		ln_expect_t  exp_r;
		logic        neg;
		x_t          mag_num;
		logic [127:0] numer, den, quot, rest;
		frac_t       mag_y, y_sq, pw;
		logic [63:0] sum, t, d, r, mag_res;
		logic [64:0] acc;
		int          lim;
		exp_r.arg = arg;
		exp_r.inv = 1'b0;
		if (arg == '0) begin
			exp_r.ln  = LN_NEG_LIM;
			exp_r.inv = 1'b1;
			return exp_r;
		end
		// y = (x - 1) / (x + 1) as a magnitude with its sign held apart.
		neg = arg < ONE_Q16;
		mag_num = neg ? ONE_Q16 - arg : arg - ONE_Q16;
		numer = mag_num;
		numer = numer << FRAC_Y;
		den = arg;
		den = den + ONE_Q16;
		quot = numer / den;
		rest = numer % den;
		if ((rest << 1) >= den)
			quot = quot + 1'b1;
		mag_y = (quot > Y_MAX) ? Y_MAX : quot[FRAC_Y-1:0];
		y_sq = frac_product(mag_y, mag_y);
		lim = (count > MAX_TERMS) ? int'(MAX_TERMS) : int'(count);
		// Odd powers divided by 2n+1, summed with saturation; stops once the power vanishes.
		sum = '0;
		pw = mag_y;
		for (int n = 0; n < lim && pw != '0; n++) begin
			d = 2 * n + 1;
			t = pw / d;
			r = pw % d;
			if ((r << 1) >= d)
				t = t + 1'b1;
			acc = {1'b0, sum} + t;
			sum = acc[64] ? '1 : acc[63:0];
			pw = frac_product(pw, y_sq);
		end
		// Twice the sum at 32 fraction bits, rounded, then signed and saturated.
		mag_res = (sum >> 27) + sum[26];
		if (neg) begin
			if (mag_res > LN_NEG_LIM)
				mag_res = LN_NEG_LIM;
			exp_r.ln = ~mag_res[LN_W-1:0] + 1'b1;
		end else begin
			exp_r.ln = (mag_res > LN_POS_LIM) ? LN_POS_LIM : mag_res[LN_W-1:0];
		end
		return exp_r;
	endfunction

	// Watch the three channels; results are checked before a new item is queued.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			terms_shadow <= TERMS_RESET;
			ln_expected_q.delete();
			ln_outstanding <= 0;
			ln_mismatches <= fail_tally;
		end else begin
			if (done) begin
				if (ln_expected_q.size() == 0) begin
					fail_tally++;
					if (fail_tally <= SHOWN_MAX)
						$display("%0t: result with none expected: ln=%h invalid=%b",
							$realtime, ln_value, invalid);
				end else begin
					want = ln_expected_q.pop_front();
					if (ln_value !== want.ln || invalid !== want.inv) begin
						fail_tally++;
						if (fail_tally <= SHOWN_MAX)
							$display("%0t: x=%h expected ln=%h invalid=%b, got ln=%h invalid=%b",
								$realtime, want.arg, want.ln, want.inv, ln_value, invalid);
					end
				end
			end
			if (start && !busy)
				ln_expected_q.push_back(predict_ln(x_value, terms_shadow));
			if (cfg_valid && cfg_ready)
				terms_shadow <= cfg_data;
			ln_outstanding <= ln_expected_q.size();
			ln_mismatches <= fail_tally;
		end
	end

endmodule

@@ tb/sv/tb_natural_log_atanh_series.sv @@
// Testbench top for the natural logarithm block: clock, reset, stimulus and verdict.
// Depends on nlas_pkg, the block itself and nlas_result_checker, which does the comparing.
`timescale 1ns / 1ps

module tb_natural_log_atanh_series;

	import nlas_pkg::*;

	localparam int QUIET_LIMIT = 100000;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	x_t               x_value;
	logic             done;
	logic signed [LN_W-1:0] ln_value;
	logic             invalid;
	logic             cfg_valid;
	logic             cfg_ready;
	terms_t           cfg_data;
	int               ln_mismatches;
	int               ln_outstanding;

	int               quiet_cycles = 0;
	int               args_sent = 0;
	int               zero_args = 0;
	int               settings_used = 0;
	logic             burst_mode = 1'b0;
	terms_t           last_terms = TERMS_RESET;

	natural_log_atanh_series dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.x_value   (x_value),
		.done      (done),
		.ln_value  (ln_value),
		.invalid   (invalid),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	nlas_result_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.x_value        (x_value),
		.done           (done),
		.ln_value       (ln_value),
		.invalid        (invalid),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.ln_mismatches  (ln_mismatches),
		.ln_outstanding (ln_outstanding)
	);

	// 10 ns clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog: ends the run when no item, result or register write moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Watchdog expired after %0d quiet cycles.", quiet_cycles);
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Offer one argument after a random pause; returns at the edge that takes it, with
	// start still high so that a following item can go without a gap.
	task automatic feed_arg(input x_t arg);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		x_value <= arg;
		do @(posedge clk); while (busy);
		args_sent++;
		if (arg == '0)
			zero_args++;
	endtask

	// Write the term count once every awaited result has come and the block is idle.
	task automatic write_terms(input terms_t count);
		start <= 1'b0;
		do @(posedge clk); while (ln_outstanding != 0 || busy);
		repeat ($urandom_range(0, 11)) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= count;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_data  <= terms_t'($urandom);
		last_terms = count;
		settings_used++;
	endtask

	// Random argument, weighted towards the regions where the series behaves differently.
	function automatic x_t draw_arg();
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1, 2, 9: return w[X_W-1:0];
			3:          return w[X_W-1:0] >> $urandom_range(1, X_W - 1);
			4:          return ONE_Q16 + x_t'($urandom_range(0, 64)) - x_t'(32);
			5:          return x_t'($urandom_range(1, 65535));
			6:          return x_t'($urandom_range(1, 1 << 20));
			7:          return '0;
			default: begin
				case ($urandom_range(0, 2))
					0:       return x_t'(1);
					1:       return '1;
					default: return ONE_Q16;
				endcase
			end
		endcase
	endfunction

	// Stimulus: directed arguments and term counts, then random phases.
	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		x_value   = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset term count: zero, one, the extremes and a few landmarks.
		feed_arg('0);
		feed_arg(ONE_Q16);
		feed_arg(x_t'(1));
		feed_arg('1);
		feed_arg(48'h0000_0000_8000);
		feed_arg(48'h0000_0001_0001);
		feed_arg(48'h0000_0000_FFFF);
		feed_arg(48'h0000_0002_0000);
		feed_arg(48'h0000_0002_B7E1);
		feed_arg(48'h0001_0000_0000);
		feed_arg(48'h5555_5555_5555);
		feed_arg(48'hAAAA_AAAA_AAAA);

		// A zero term count sums nothing.
		write_terms('0);
		feed_arg(48'h0000_0002_0000);
		feed_arg('0);
		feed_arg('1);

		// A count above the maximum is cut to the maximum; then the maximum itself.
		write_terms('1);
		feed_arg(x_t'(1));
		feed_arg('1);
		write_terms(MAX_TERMS);
		feed_arg(48'h0000_0003_0000);

		// A single term.
		write_terms(terms_t'(1));
		feed_arg(48'h0000_0000_8000);
		feed_arg('1);

		// Random phases over modest term counts; odd phases run back to back.
		for (int ph = 0; ph < 5; ph++) begin
			burst_mode = (ph % 2 == 1);
			write_terms((ph == 4) ? terms_t'($urandom_range(1, 4))
				: terms_t'($urandom_range(2, 48)));
			repeat (20) feed_arg(draw_arg());
		end

		start <= 1'b0;
		do @(posedge clk); while (ln_outstanding != 0);
		repeat (70 + 23 * int'(last_terms) + 20) @(posedge clk);

		$display("Covered %0d arguments, %0d of them zero, across the reset count and %0d",
			args_sent, zero_args, settings_used);
		$display("written term counts from zero through the maximum and beyond it.");
		if (ln_mismatches == 0 && ln_outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
